// ----- rtl/dis_pkg.sv -----
// Package for the disjoint interval set: sizes, codes and shared types.
// No dependencies; every other file imports it.
package dis_pkg;

   localparam int MAX_INTERVALS = 64;
   localparam int KEY_BITS      = 32;
   localparam int IDX_W         = $clog2(MAX_INTERVALS);
   localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
   localparam int ADDR_W        = IDX_W + 1;

   localparam logic [KEY_BITS-1:0] KEY_MAX = {KEY_BITS{1'b1}};
   localparam logic [CNT_W-1:0]    CNT_FULL = CNT_W'(MAX_INTERVALS);

   typedef logic [KEY_BITS-1:0] key_type;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RD1, S_EV1, S_DECIDE, S_RD2, S_EV2, S_EV2B, S_FIN, S_RESP
   } state_type;

   typedef struct packed {
      key_type first;
      key_type last;
   } entry_type;

   // result of evaluating one stored entry against the working range
   typedef struct packed {
      logic      chk;
      logic      w1_v;
      entry_type w1;
      logic      w2_v;
      entry_type w2;
      key_type   lo;
      key_type   hi;
      logic      placed;
   } eval_type;

endpackage

// ----- rtl/dis_store.sv -----
// Interval storage: two banks of entries, one read and one write port.
// Depends on dis_pkg.
module dis_store (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [dis_pkg::ADDR_W-1:0] wr_addr,
   input  dis_pkg::entry_type        wr_data,
   input  logic [dis_pkg::ADDR_W-1:0] rd_addr,
   output dis_pkg::entry_type        rd_data
);
   import dis_pkg::*;

   entry_type mem [2*MAX_INTERVALS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/dis_eval.sv -----
// Per-entry compare unit: check flag, rewrite entries and merged range.
// Depends on dis_pkg.
module dis_eval (
   input  dis_pkg::func_type  func,
   input  dis_pkg::entry_type ent,
   input  dis_pkg::key_type   lo,
   input  dis_pkg::key_type   hi,
   input  logic               placed,
   output dis_pkg::eval_type  res
);
   import dis_pkg::*;

   logic gap_l, gap_r;

   always_comb begin
      gap_l = (lo != '0) && (ent.last < lo - key_type'(1));
      gap_r = (hi != KEY_MAX) && (ent.first > hi + key_type'(1));
      res = '0;
      res.lo = lo;
      res.hi = hi;
      res.placed = placed;
      case (func)
         FUNC_ADD: begin
            res.chk = !gap_l && !gap_r;
            if (gap_l) begin
               res.w1_v = 1'b1;
               res.w1 = ent;
            end else if (gap_r) begin
               res.w1_v = 1'b1;
               if (!placed) begin
                  res.w1 = '{first: lo, last: hi};
                  res.w2_v = 1'b1;
                  res.w2 = ent;
                  res.placed = 1'b1;
               end else begin
                  res.w1 = ent;
               end
            end else begin
               if (ent.first < lo) res.lo = ent.first;
               if (ent.last > hi) res.hi = ent.last;
            end
         end
         FUNC_REMOVE: begin
            res.chk = (ent.first < lo) && (ent.last > hi);
            if (ent.last < lo || ent.first > hi) begin
               res.w1_v = 1'b1;
               res.w1 = ent;
            end else begin
               // left piece goes first, right piece follows
               if (ent.first < lo) begin
                  res.w1_v = 1'b1;
                  res.w1 = '{first: ent.first, last: lo - key_type'(1)};
                  if (ent.last > hi) begin
                     res.w2_v = 1'b1;
                     res.w2 = '{first: hi + key_type'(1), last: ent.last};
                  end
               end else if (ent.last > hi) begin
                  res.w1_v = 1'b1;
                  res.w1 = '{first: hi + key_type'(1), last: ent.last};
               end
            end
         end
         FUNC_QUERY: begin
            res.chk = (lo >= ent.first) && (lo <= ent.last);
         end
         default: begin
            res.chk = 1'b0;
         end
      endcase
   end
endmodule

// ----- rtl/disjoint_interval_set.sv -----
// Disjoint interval set: sequencer over a banked entry store.
// A query or a full-table reject makes only the check pass; add/remove also
// rewrite, and a range error or the unused code goes straight to the response;
// busy stays high while a transaction runs, results are never stalled.
// Each entry is read then evaluated by the single compare unit, one pass to
// check and one to rewrite into the other bank. Synchronous reset empties the set.
module disjoint_interval_set (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_func,
   input  logic [31:0]              req_key_low,
   input  logic [31:0]              req_key_high,
   output logic                     rsp_valid,
   output logic                     rsp_alive,
   output logic [dis_pkg::CNT_W-1:0] rsp_interval_count,
   output logic [1:0]               rsp_status
);
   import dis_pkg::*;

   state_type  state_ff, state_in;
   func_type   func_ff, func_in;
   key_type    lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0] idx_ff, idx_in, n_ff, n_in, count_ff, count_in;
   logic       bank_ff, bank_in, flag_ff, flag_in, placed_ff, placed_in;
   logic       alive_ff, alive_in;
   status_type status_ff, status_in;
   entry_type  w2_ff, w2_in;

   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   entry_type        wr_data, rd_data;
   eval_type         ev;
   logic [CNT_W-1:0] idx_nx;

   dis_store u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   dis_eval u_eval (
      .func  (func_ff),
      .ent   (rd_data),
      .lo    (lo_ff),
      .hi    (hi_ff),
      .placed(placed_ff),
      .res   (ev)
   );

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_alive = alive_ff;
   assign rsp_interval_count = count_ff;
   assign rsp_status = status_ff;
   assign rd_addr = {bank_ff, idx_ff[IDX_W-1:0]};
   assign idx_nx = idx_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bank_ff  <= bank_in;
      end
      func_ff   <= func_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      n_ff      <= n_in;
      flag_ff   <= flag_in;
      placed_ff <= placed_in;
      alive_ff  <= alive_in;
      status_ff <= status_in;
      w2_ff     <= w2_in;
   end

   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      count_in  = count_ff;
      bank_in   = bank_ff;
      flag_in   = flag_ff;
      placed_in = placed_ff;
      alive_in  = alive_ff;
      status_in = status_ff;
      w2_in     = w2_ff;
      wr_en     = 1'b0;
      wr_addr   = {~bank_ff, n_ff[IDX_W-1:0]};
      wr_data   = ev.w1;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in   = func_type'(req_func);
               lo_in     = req_key_low;
               hi_in     = req_key_high;
               idx_in    = '0;
               flag_in   = 1'b0;
               alive_in  = 1'b0;
               status_in = ST_OK;
               if (func_type'(req_func) == FUNC_NONE) begin
                  state_in = S_RESP;
               end else if (func_type'(req_func) != FUNC_QUERY &&
                            req_key_low > req_key_high) begin
                  status_in = ST_RANGE;
                  state_in  = S_RESP;
               end else if (count_ff == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  state_in = S_RD1;
               end
            end
         end
         S_RD1: state_in = S_EV1;
         S_EV1: begin
            flag_in = flag_ff | ev.chk;
            idx_in  = idx_nx;
            state_in = (idx_nx == count_ff) ? S_DECIDE : S_RD1;
         end
         S_DECIDE: begin
            idx_in    = '0;
            n_in      = '0;
            placed_in = 1'b0;
            if (func_ff == FUNC_QUERY) begin
               alive_in = !flag_ff;
               state_in = S_RESP;
            end else if (count_ff == CNT_FULL &&
                         ((func_ff == FUNC_ADD && !flag_ff) ||
                          (func_ff == FUNC_REMOVE && flag_ff))) begin
               status_in = ST_FULL;
               state_in  = S_RESP;
            end else if (count_ff == '0) begin
               state_in = S_FIN;
            end else begin
               state_in = S_RD2;
            end
         end
         S_RD2: state_in = S_EV2;
         S_EV2: begin
            wr_en     = ev.w1_v;
            wr_data   = ev.w1;
            n_in      = ev.w1_v ? n_ff + CNT_W'(1) : n_ff;
            lo_in     = ev.lo;
            hi_in     = ev.hi;
            placed_in = ev.placed;
            w2_in     = ev.w2;
            idx_in    = idx_nx;
            if (ev.w2_v) begin
               state_in = S_EV2B;
            end else begin
               state_in = (idx_nx == count_ff) ? S_FIN : S_RD2;
            end
         end
         S_EV2B: begin
            wr_en    = 1'b1;
            wr_data  = w2_ff;
            n_in     = n_ff + CNT_W'(1);
            state_in = (idx_ff == count_ff) ? S_FIN : S_RD2;
         end
         S_FIN: begin
            // an add that met no later disjoint entry lands at the tail
            if (func_ff == FUNC_ADD && !placed_ff) begin
               wr_en   = 1'b1;
               wr_data = '{first: lo_ff, last: hi_ff};
               count_in = n_ff + CNT_W'(1);
            end else begin
               count_in = n_ff;
            end
            bank_in  = ~bank_ff;
            state_in = S_RESP;
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ----- tb/sv/tb.sv -----
// Testbench for disjoint_interval_set: directed and random add/remove/query traffic.
// Depends on dis_pkg and the disjoint_interval_set RTL; prediction is local.
`timescale 1ns / 100ps

module tb;
   import dis_pkg::*;

   typedef struct {
      func_type func;
      key_type  lo;
      key_type  hi;
      int       gap;
      bit       drain;
   } request_type;

   typedef struct {
      logic                 alive;
      logic [CNT_W-1:0]     count;
      status_type           status;
   } answer_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_func = 2'd0;
   logic [31:0]       req_key_low = '0;
   logic [31:0]       req_key_high = '0;
   logic              rsp_valid;
   logic              rsp_alive;
   logic [CNT_W-1:0]  rsp_interval_count;
   logic [1:0]        rsp_status;

   disjoint_interval_set dut (.*);

   always #10 clock = ~clock;

   request_type pending_q[$];
   answer_type  answer_q[$];
   int       mismatches = 0;
   bit       stim_done = 1'b0;

   // predictor state
   key_type set_lo[$];
   key_type set_hi[$];

   function automatic answer_type predict_answer(request_type r);
      answer_type a;
      key_type nlo[$];
      key_type nhi[$];
      key_type lo, hi, s, e;
      int touched;
      bit placed, splits, gl, gr;
      a.alive = 1'b0;
      a.status = ST_OK;
      lo = r.lo;
      hi = r.hi;
      touched = 0;
      placed = 1'b0;
      splits = 1'b0;
      if ((r.func == FUNC_ADD || r.func == FUNC_REMOVE) && lo > hi)
         a.status = ST_RANGE;
      else if (r.func == FUNC_ADD) begin
         foreach (set_lo[i]) begin
            gl = lo > 0 && set_hi[i] < lo - 1;
            gr = hi < KEY_MAX && set_lo[i] > hi + 1;
            if (!gl && !gr) touched++;
         end
         if (touched == 0 && set_lo.size() >= MAX_INTERVALS)
            a.status = ST_FULL;
         else begin
            foreach (set_lo[i]) begin
               s = set_lo[i];
               e = set_hi[i];
               if (lo > 0 && e < lo - 1) begin
                  nlo = {nlo, s}; nhi = {nhi, e};
               end else if (hi < KEY_MAX && s > hi + 1) begin
                  if (!placed) begin
                     nlo = {nlo, lo}; nhi = {nhi, hi}; placed = 1'b1;
                  end
                  nlo = {nlo, s}; nhi = {nhi, e};
               end else begin
                  if (s < lo) lo = s;
                  if (e > hi) hi = e;
               end
            end
            if (!placed) begin
               nlo = {nlo, lo}; nhi = {nhi, hi};
            end
            set_lo = nlo;
            set_hi = nhi;
         end
      end else if (r.func == FUNC_REMOVE) begin
         foreach (set_lo[i])
            if (set_lo[i] < lo && set_hi[i] > hi) splits = 1'b1;
         if (splits && set_lo.size() >= MAX_INTERVALS)
            a.status = ST_FULL;
         else begin
            foreach (set_lo[i]) begin
               s = set_lo[i];
               e = set_hi[i];
               if (e < lo || s > hi) begin
                  nlo = {nlo, s}; nhi = {nhi, e};
               end else begin
                  if (s < lo) begin
                     nlo = {nlo, s}; nhi = {nhi, key_type'(lo - 1)};
                  end
                  if (e > hi) begin
                     nlo = {nlo, key_type'(hi + 1)}; nhi = {nhi, e};
                  end
               end
            end
            set_lo = nlo;
            set_hi = nhi;
         end
      end else if (r.func == FUNC_QUERY) begin
         a.alive = 1'b1;
         foreach (set_lo[i])
            if (lo >= set_lo[i] && lo <= set_hi[i]) a.alive = 1'b0;
      end
      a.count = CNT_W'(set_lo.size());
      return a;
   endfunction

   // busy as seen just before the last rising edge
   logic busy_at_edge = 1'b1;

   // driver
   int          wait_left = 0;
   request_type cur;
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy_at_edge) begin
         // previous transaction taken at the last rising edge
         start <= 1'b0;
      end else if (!start) begin
         if (pending_q.size() > 0) begin
            if (wait_left < pending_q[0].gap) wait_left++;
            else if (!pending_q[0].drain || answer_q.size() == 0) begin
               wait_left = 0;
               cur = pending_q.pop_front();
               req_func <= cur.func;
               req_key_low <= cur.lo;
               req_key_high <= cur.hi;
               start <= 1'b1;
            end
         end else
            stim_done = 1'b1;
      end
   end

   // accept point and predictor update at the rising edge
   always @(posedge clock) begin
      request_type r;
      busy_at_edge <= busy;
      if (!reset && start && !busy) begin
         r.func = func_type'(req_func);
         r.lo = req_key_low;
         r.hi = req_key_high;
         answer_q = {answer_q, predict_answer(r)};
      end
   end

   // monitor
   always @(posedge clock) begin
      answer_type x;
      if (!reset && rsp_valid) begin
         if (answer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction result");
         end else begin
            x = answer_q.pop_front();
            if (rsp_alive !== x.alive || rsp_interval_count !== x.count
                || rsp_status !== x.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp alive %0d count %0d status %0d, got %b %0d %0d",
                           x.alive, x.count, x.status, rsp_alive,
                           rsp_interval_count, rsp_status);
            end
         end
      end
   end

   function automatic key_type pick_key(int mode);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return KEY_MAX;
         2: return $urandom();
         default: return mode ? 32'(1000 + $urandom_range(0, 400))
                              : 32'($urandom_range(0, 400));
      endcase
   endfunction

   task automatic queue_item(func_type f, key_type lo, key_type hi, bit drain = 0);
      request_type r;
      r.func = f;
      r.lo = lo;
      r.hi = hi;
      r.drain = drain;
      r.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      pending_q = {pending_q, r};
   endtask

   initial begin
      key_type a, b;
      int f, w;
      // directed: edges, all operations, range error, unused code
      queue_item(FUNC_QUERY, 0, 0);
      queue_item(FUNC_ADD, 5, 3);
      queue_item(FUNC_REMOVE, KEY_MAX, 0);
      queue_item(FUNC_ADD, 0, 0);
      queue_item(FUNC_ADD, KEY_MAX, KEY_MAX);
      queue_item(FUNC_ADD, 2, 4);
      queue_item(FUNC_ADD, 1, 1);
      queue_item(FUNC_QUERY, KEY_MAX, 0);
      queue_item(FUNC_QUERY, 5, 0);
      queue_item(FUNC_NONE, 32'hAAAA5555, 32'h5555AAAA);
      queue_item(FUNC_REMOVE, 2, 2);
      queue_item(FUNC_REMOVE, KEY_MAX - 1, KEY_MAX);
      queue_item(FUNC_ADD, 0, KEY_MAX);
      queue_item(FUNC_REMOVE, 1, KEY_MAX - 1);
      queue_item(FUNC_REMOVE, 0, KEY_MAX, 1);
      // fill to capacity: 64 isolated points
      for (int i = 0; i < MAX_INTERVALS; i++) queue_item(FUNC_ADD, 10 * i, 10 * i);
      queue_item(FUNC_ADD, 5000, 5000);
      queue_item(FUNC_ADD, 1, 1);
      queue_item(FUNC_ADD, 3, 7);
      queue_item(FUNC_REMOVE, 30, 30);
      queue_item(FUNC_ADD, 3, 7);
      queue_item(FUNC_REMOVE, 20, 20);
      queue_item(FUNC_ADD, 20, 20);
      queue_item(FUNC_ADD, 20, 29);
      queue_item(FUNC_REMOVE, 22, 25, 1);
      queue_item(FUNC_REMOVE, 0, KEY_MAX);
      // random: dense small-key traffic, sometimes wide keys
      for (int i = 0; i < 1500; i++) begin
         w = (i / 300) % 2;
         f = $urandom_range(0, 19);
         a = pick_key(w);
         b = ($urandom_range(0, 3) == 0) ? pick_key(w) : a + $urandom_range(0, 12);
         if (b < a && $urandom_range(0, 4) != 0) b = a;
         if (f < 9) queue_item(FUNC_ADD, a, b, i % 250 == 0);
         else if (f < 14) queue_item(FUNC_REMOVE, a, b);
         else if (f < 19) queue_item(FUNC_QUERY, a, $urandom());
         else queue_item(FUNC_NONE, a, b);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && answer_q.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && answer_q.size() == 0)
         $display("disjoint_interval_set regression: pass");
      else
         $display("disjoint_interval_set regression: fail");
      $finish;
   end

   initial begin
      #100ms;
      $display("disjoint_interval_set regression: fail");
      $finish;
   end
endmodule
